/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted-array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  // Built depth of the cell chain by default
  localparam int unsigned DepthDef = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 4;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CountW   = 4;

  localparam logic [CapW-1:0] CapReset = CapW'(8);

  // Operation codes
  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  // Status codes
  localparam logic [StatW-1:0] StEnqueued = 2'd0;
  localparam logic [StatW-1:0] StFull     = 2'd1;
  localparam logic [StatW-1:0] StDequeued = 2'd2;
  localparam logic [StatW-1:0] StEmpty    = 2'd3;

  localparam logic signed [DataW-1:0] EmptyValue = -32'sd1;

  // Input beat
  typedef struct packed {
    logic                    operation;
    logic signed [DataW-1:0] item_value;
  } spq_in_t;

  // Result beat
  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       entry_count;
  } spq_out_t;

  // Chain-wide control broadcast to every cell
  typedef struct packed {
    logic insert;   // enqueue accepted and not refused
    logic remove;   // dequeue accepted on a non-empty queue
  } spq_ctrl_t;

endpackage
`default_nettype wire

/* hdl/spq_cell.sv */
// One cell of the sorted chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire                     clk_i,
  input  spq_ctrl_t               ctrl_i,
  input  wire                     occ_i,
  input  wire signed [DataW-1:0]  new_value_i,
  input  wire signed [DataW-1:0]  left_value_i,
  input  wire                     left_ge_i,
  input  wire signed [DataW-1:0]  right_value_i,
  output logic signed [DataW-1:0] value_o,
  output logic                    ge_o
);

  logic signed [DataW-1:0] value_q, value_d;

  // Stay in front of the new value when occupied and not smaller
  assign ge_o = occ_i && (value_q >= new_value_i);

  // Keep, take new value, take left neighbor, or take right neighbor
  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (!ge_o) begin
        value_d = left_ge_i ? new_value_i : left_value_i;
      end
    end else if (ctrl_i.remove) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

/* hdl/sorted_array_priority_queue_core.sv */
// Top level of the sorted-array priority queue: count, capacity and cell chain.
// The result beat shows on done_o in the cycle after start is taken.
// Throughput: one operation per cycle; every cell compares and shifts in the
// same cycle, so busy stays low.
// Reset: count clears to zero, capacity limit returns to 8, no result pending.
// The receiver cannot stall; each result beat lasts exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module sorted_array_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  spq_in_t          in_i,
  output logic             done_o,
  output spq_out_t         result_o,
  input  wire              cfg_we_i,
  input  wire [CapW-1:0]   cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  logic [CntW-1:0] count_q, count_d;
  logic [CapW-1:0] cap_q;
  logic            done_q;
  spq_out_t        result_q, result_d;

  logic                    accept;
  logic                    full;
  logic                    empty;
  spq_ctrl_t               ctrl;
  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        ge;
  logic signed [DataW-1:0] cell_value [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Refuse when count reaches the limit or the built depth
  assign full  = (CmpW'(count_q) >= CmpW'(cap_q)) || (CmpW'(count_q) >= CmpW'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl = '{insert: accept && (in_i.operation == OpEnq) && !full,
                  remove: accept && (in_i.operation == OpDeq) && !empty};

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_value;
    logic                    left_ge;
    logic signed [DataW-1:0] right_value;

    assign occ[i] = (CmpW'(count_q) > CmpW'(i));

    if (i == 0) begin : g_head
      assign left_value = in_i.item_value;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .new_value_i   (in_i.item_value),
      .left_value_i  (left_value),
      .left_ge_i     (left_ge),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .ge_o          (ge[i])
    );
  end

  // Next count
  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Form the result beat
  always_comb begin
    result_d.result_value = '0;
    result_d.status       = StEnqueued;
    if (in_i.operation == OpEnq) begin
      result_d.status = full ? StFull : StEnqueued;
    end else if (empty) begin
      result_d.result_value = EmptyValue;
      result_d.status       = StEmpty;
    end else begin
      result_d.result_value = cell_value[0];
      result_d.status       = StDequeued;
    end
    result_d.entry_count = CountW'(CmpW'(count_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CapReset;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload holds no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted beat gives exactly one result beat next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without accepted beat");

  // Count never passes the built depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(DEPTH))
    else $error("count beyond depth");

  // A refused enqueue or empty dequeue leaves the count alone
  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ctrl.insert && !ctrl.remove) |=> $stable(count_q))
    else $error("count moved on refused beat");

  // Insert and remove never fire together
  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.insert && ctrl.remove))
    else $error("insert and remove together");

endmodule
`default_nettype wire

/* tb/tb_sorted_array_priority_queue_core.sv */
// Self-checking bench for the sorted-array priority queue core: random and directed beats.
`timescale 1ns / 1ps
module tb_sorted_array_priority_queue_core;
  import spq_pkg::*;

  localparam int unsigned StallLimit = 500;

  typedef enum logic [1:0] {StepBeat, StepCapWrite, StepSettle} step_kind_e;

  // One entry of the stimulus plan: a beat, a capacity write or a pause
  typedef struct {
    step_kind_e      kind;
    logic            steady;
    spq_in_t         beat;
    logic [CapW-1:0] cap;
  } plan_step_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  spq_in_t         in_i = '0;
  logic            done_o;
  spq_out_t        result_o;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  plan_step_t queued_ops[$];
  spq_out_t   predicted_results[$];

  // Shadow copy of the queue contents and the capacity register
  logic signed [DataW-1:0] ranked[DepthDef];
  int unsigned             held = 0;
  logic [CapW-1:0]         cap_limit = CapReset;

  logic        beat_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;

  sorted_array_priority_queue_core #(
    .DEPTH(DepthDef)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one operation to the shadow queue and return the result beat it yields
  function automatic spq_out_t next_queue_result(spq_in_t beat);
    spq_out_t    res;
    int unsigned usable;
    int unsigned pos;
    int unsigned k;
    res = '0;
    usable = (cap_limit > DepthDef) ? DepthDef : int'(cap_limit);
    if (beat.operation == OpEnq) begin
      if (held >= usable) begin
        res.status = StFull;
      end else begin
        // shift smaller entries back; equal ones stay ahead
        pos = held;
        while (pos > 0 && ranked[pos-1] < beat.item_value) begin
          ranked[pos] = ranked[pos-1];
          pos--;
        end
        ranked[pos] = beat.item_value;
        held++;
        res.status = StEnqueued;
      end
    end else if (held == 0) begin
      res.result_value = EmptyValue;
      res.status = StEmpty;
    end else begin
      res.result_value = ranked[0];
      for (k = 0; k + 1 < held; k++) ranked[k] = ranked[k+1];
      held--;
      res.status = StDequeued;
    end
    res.entry_count = CountW'(held);
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(DataW-1){1'b1}}};
      1: return {1'b1, {(DataW-1){1'b0}}};
      // small pool so that equal priorities collide often
      2, 3: return DataW'($urandom_range(0, 4)) - DataW'(2);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_beat(logic op, logic signed [DataW-1:0] value, logic steady);
    plan_step_t s;
    s.kind = StepBeat;
    s.steady = steady;
    s.beat.operation = op;
    s.beat.item_value = value;
    s.cap = '0;
    queued_ops.push_back(s);
  endtask

  task automatic add_cap_write(logic [CapW-1:0] value);
    plan_step_t s;
    s.kind = StepCapWrite;
    s.steady = 1'b0;
    s.beat = '0;
    s.cap = value;
    queued_ops.push_back(s);
  endtask

  task automatic add_settle();
    plan_step_t s;
    s.kind = StepSettle;
    s.steady = 1'b0;
    s.beat = '0;
    s.cap = '0;
    queued_ops.push_back(s);
  endtask

  // Runs of enqueues and dequeues so the queue swings between full and empty
  task automatic add_random_run(int unsigned n_ops, logic steady);
    int unsigned made;
    int unsigned run_len;
    int unsigned k;
    logic        op;
    made = 0;
    while (made < n_ops) begin
      if (!steady && $urandom_range(0, 39) == 0) add_settle();
      if ($urandom_range(0, 9) == 0) begin
        add_beat(1'($urandom_range(0, 1)), pick_value(), steady);
        made++;
      end else begin
        op = 1'($urandom_range(0, 1));
        run_len = $urandom_range(1, 10);
        for (k = 0; k < run_len; k++) add_beat(op, pick_value(), steady);
        made += run_len;
      end
    end
  endtask

  // Drive beats and register writes on the falling edge
  always @(negedge clk_i) begin : drive_beats
    plan_step_t      head;
    logic            next_start;
    logic            next_we;
    spq_in_t         next_beat;
    logic [CapW-1:0] next_cap;
    next_start = 1'b0;
    next_we = 1'b0;
    next_beat = in_i;
    next_cap = cfg_wdata_i;
    if (rst_ni) begin
      if (start && beat_taken) queued_ops.delete(0);
      if (queued_ops.size() > 0) begin
        head = queued_ops[0];
        case (head.kind)
          StepBeat: begin
            if (start && !beat_taken) begin
              // hold the beat until it is taken
              next_start = 1'b1;
              next_beat = head.beat;
            end else if (gap_left > 0) begin
              gap_left--;
            end else if (!head.steady && $urandom_range(0, 7) == 0) begin
              gap_left = $urandom_range(0, 2);
            end else begin
              next_start = 1'b1;
              next_beat = head.beat;
            end
          end
          StepCapWrite: begin
            if (predicted_results.size() == 0) begin
              next_we = 1'b1;
              next_cap = head.cap;
              queued_ops.delete(0);
            end
          end
          default: begin
            if (predicted_results.size() == 0) queued_ops.delete(0);
          end
        endcase
      end
    end
    start <= next_start;
    in_i <= next_beat;
    cfg_we_i <= next_we;
    cfg_wdata_i <= next_cap;
  end

  // Check result beats, then take the new beat and predict its result
  always @(posedge clk_i) begin : watch_results
    spq_out_t want;
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no expected result outstanding");
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (result_o.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   result_o.result_value);
            mismatch_count++;
          end
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            mismatch_count++;
          end
          if (result_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   result_o.entry_count);
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      if (start && busy === 1'b0) begin
        beat_taken = 1'b1;
        predicted_results.push_back(next_queue_result(in_i));
      end
      // watchdog: end the run if nothing moves for too long
      if (beat_taken || done_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run_plan
    int unsigned k;
    logic [CapW-1:0] caps[9];
    caps = '{4'd1, 4'd15, 4'd0, 4'd9, 4'd3, 4'd8, 4'd5, 4'd2, 4'd8};

    // directed: empty dequeue, extremes, ties, full refusal, drain in order
    add_beat(OpDeq, $urandom, 1'b0);
    add_beat(OpEnq, {1'b0, {(DataW-1){1'b1}}}, 1'b0);
    add_beat(OpEnq, {1'b1, {(DataW-1){1'b0}}}, 1'b0);
    add_beat(OpEnq, '0, 1'b0);
    add_beat(OpEnq, EmptyValue, 1'b0);
    add_beat(OpEnq, 32'sd5, 1'b0);
    add_beat(OpEnq, 32'sd5, 1'b0);
    add_beat(OpEnq, 32'sd1, 1'b0);
    add_beat(OpEnq, {1'b0, {(DataW-1){1'b1}}}, 1'b0);
    add_beat(OpEnq, 32'sd7, 1'b0);
    for (k = 0; k < 9; k++) add_beat(OpDeq, $urandom, 1'b0);

    // capacity lowered below the stored count
    add_cap_write(4'd8);
    for (k = 0; k < 8; k++) add_beat(OpEnq, pick_value(), 1'b0);
    add_cap_write(4'd2);
    add_beat(OpEnq, pick_value(), 1'b0);
    add_beat(OpEnq, pick_value(), 1'b0);
    for (k = 0; k < 7; k++) add_beat(OpDeq, pick_value(), 1'b0);
    add_beat(OpEnq, pick_value(), 1'b0);
    add_beat(OpEnq, pick_value(), 1'b0);
    for (k = 0; k < 3; k++) add_beat(OpDeq, pick_value(), 1'b0);

    // random phases across capacity settings, the last one without idling
    for (k = 0; k < 9; k++) begin
      add_settle();
      add_cap_write(caps[k]);
      add_random_run(80, k == 8);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (queued_ops.size() != 0 || predicted_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
